// File: hw/rtl/bf16div_pkg.sv
// Package for the bfloat16 divider: encodings, widths and state codes.
// Used by the interface file and all modules; depends on nothing.
`default_nettype none
package bf16div_pkg;
  localparam int WordW = 16;
  localparam int StepW = 5;
  localparam logic [15:0] QNan = 16'h7FC0;
  localparam logic [15:0] InfBits = 16'h7F80;
  localparam logic [7:0] ExpMax = 8'hFF;
  localparam logic [5:0] DivSteps = 6'd16;
  localparam logic [9:0] Bias = 10'd127;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_NORM = 5'b00100,
    S_PACK = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } ctl_t;
endpackage
`default_nettype wire

// File: hw/rtl/bf16div_if.sv
// Valid/ready channel carrying one bfloat16 word or operand pair.
// Depends on bf16div_pkg for the word width.
`default_nettype none
interface bf16div_in_if;
  logic valid;
  logic ready;
  logic [bf16div_pkg::WordW-1:0] dividend_word;
  logic [bf16div_pkg::WordW-1:0] divisor_word;
  modport source(output valid, dividend_word, divisor_word, input ready);
  modport sink(input valid, dividend_word, divisor_word, output ready);
endinterface

interface bf16div_out_if;
  logic valid;
  logic ready;
  logic [bf16div_pkg::WordW-1:0] quotient_word;
  modport source(output valid, quotient_word, input ready);
  modport sink(input valid, quotient_word, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bf16div_core.sv
// Bit-serial restoring divider: one quotient bit per cycle, producing a 16-bit quotient.
// Depends on bf16div_pkg.
`default_nettype none
module bf16div_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [7:0] mant_a,
  input  wire logic [7:0] mant_b,
  output logic done,
  output logic [15:0] quo
);
  logic [8:0] rem;
  logic [7:0] dvs;
  logic [4:0] cnt;
  logic busy;
  logic ovf;
  logic [9:0] trial;

  // Remainder shifted left once per step, compared against the divisor.
  assign trial = {rem, quo[15]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == bf16div_pkg::DivSteps[4:0] - 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // A dividend of at least twice the divisor sets every quotient bit to one.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, mant_a} >> 1;
      dvs <= mant_b;
      quo <= {mant_a[0], 15'd0};
      ovf <= {1'b0, mant_a} >= {mant_b, 1'b0};
    end else if (busy) begin
      if (ovf) begin
        quo <= {quo[14:0], 1'b1};
      end else if (!trial[9]) begin
        rem <= trial[8:0];
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= {rem[7:0], quo[15]};
        quo <= {quo[14:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/bfloat16_divider.sv
// bfloat16 divider, truncating, with a bit-serial restoring significand divider.
// Special cases skip the divide loop.
// One item at a time: next input accepted once the result transfer completes.
// The 16-step divide loop and the normalize shifter set the rate.
// Synchronous active-high reset clears control state only.
`default_nettype none
module bfloat16_divider (
  input wire logic clk,
  input wire logic rst,
  bf16div_in_if.sink in,
  bf16div_out_if.source out
);
  bf16div_pkg::state_t state;
  logic [15:0] a, b, res;
  logic [9:0] e;
  logic sign, special, cstart, cdone;
  logic [7:0] ma, mb;
  logic [15:0] cq, q;
  logic [7:0] ea, eb;
  logic [6:0] fa, fb;

  assign ea = a[14:7];
  assign eb = b[14:7];
  assign fa = a[6:0];
  assign fb = b[6:0];
  assign ma = {ea != 8'd0, fa};
  assign mb = {eb != 8'd0, fb};
  assign special = (eb == bf16div_pkg::ExpMax) || (eb == 8'd0 && fb == 7'd0) ||
                   (ea == bf16div_pkg::ExpMax) || (ea == 8'd0 && fa == 7'd0);
  assign in.ready = (state == bf16div_pkg::S_IDLE);
  assign out.valid = (state == bf16div_pkg::S_OUT);
  assign out.quotient_word = res;
  assign cstart = (state == bf16div_pkg::S_PACK) && !special;

  bf16div_core u_core (
    .clk(clk), .rst(rst), .start(cstart), .mant_a(ma), .mant_b(mb),
    .done(cdone), .quo(cq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bf16div_pkg::S_IDLE;
    end else begin
      unique case (state)
        bf16div_pkg::S_IDLE: begin
          if (in.valid) begin
            a <= in.dividend_word;
            b <= in.divisor_word;
            state <= bf16div_pkg::S_PACK;
          end
        end
        bf16div_pkg::S_PACK: begin
          sign <= a[15] ^ b[15];
          e <= {2'b00, ea} - {2'b00, eb} + bf16div_pkg::Bias
               - {9'd0, ea == 8'd0} + {9'd0, eb == 8'd0};
          state <= bf16div_pkg::S_OUT;
          if (eb == bf16div_pkg::ExpMax) begin
            if (fb != 7'd0) res <= b;
            else if (ea == bf16div_pkg::ExpMax && fa == 7'd0) res <= bf16div_pkg::QNan;
            else res <= {a[15] ^ b[15], 15'd0};
          end else if (eb == 8'd0 && fb == 7'd0) begin
            if (ea == 8'd0 && fa == 7'd0) res <= bf16div_pkg::QNan;
            else res <= {a[15] ^ b[15], 15'd0} | bf16div_pkg::InfBits;
          end else if (ea == bf16div_pkg::ExpMax) begin
            if (fa != 7'd0) res <= a;
            else res <= {a[15] ^ b[15], 15'd0} | bf16div_pkg::InfBits;
          end else if (ea == 8'd0 && fa == 7'd0) begin
            res <= {a[15] ^ b[15], 15'd0};
          end else begin
            state <= bf16div_pkg::S_DIV;
          end
        end
        bf16div_pkg::S_DIV: begin
          if (cdone) begin
            q <= cq;
            state <= bf16div_pkg::S_NORM;
          end
        end
        bf16div_pkg::S_NORM: begin
          if (!q[15] && !e[9] && e > 10'd1) begin
            q <= {q[14:0], 1'b0};
            e <= e - 10'd1;
          end else begin
            if (!e[9] && e >= {2'b00, bf16div_pkg::ExpMax})
              res <= {sign, 15'd0} | bf16div_pkg::InfBits;
            else if (e[9] || e == 10'd0) res <= {sign, 15'd0};
            else res <= {sign, e[7:0], q[14:8]};
            state <= bf16div_pkg::S_OUT;
          end
        end
        bf16div_pkg::S_OUT: begin
          if (out.ready) state <= bf16div_pkg::S_IDLE;
        end
        default: state <= bf16div_pkg::S_IDLE;
      endcase
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_done: assert property (@(posedge clk) disable iff (rst)
    cdone |-> state == bf16div_pkg::S_DIV) else $error("divider done out of step");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(res)) else $error("result dropped");
endmodule
`default_nettype wire

// File: tb/bfloat16_divider_tb.sv
// Self-checking testbench for the bfloat16 divider: drives operand pairs, predicts quotients.
// Depends on bf16div_pkg, the bf16div_in_if / bf16div_out_if interfaces and bfloat16_divider.
`timescale 1ns / 1ps
`default_nettype none
module bfloat16_divider_tb;

  typedef struct packed {
    logic [15:0] dividend;
    logic [15:0] divisor;
  } operand_pair_t;

  localparam int unsigned StallLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bf16div_in_if in_ch();
  bf16div_out_if out_ch();

  bfloat16_divider DUT (.clk(clk), .rst(rst), .in(in_ch), .out(out_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  operand_pair_t pending_pairs[$];
  logic [15:0] expected_quotients[$];
  int unsigned mismatch_count = 0;
  int unsigned transfers_in = 0;
  int unsigned transfers_out = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_off = 0;
  bit drain_pause = 1'b0;

  function automatic logic [15:0] bf16_quotient(logic [15:0] a, logic [15:0] b);
    logic sgn;
    int ea, eb, e, i;
    logic [31:0] ma, mb, rem, q;
    sgn = a[15] ^ b[15];
    ea = a[14:7];
    eb = b[14:7];
    ma = {25'd0, a[6:0]};
    mb = {25'd0, b[6:0]};
    if (eb == 255) begin
      if (mb != 0) return b;
      if (ea == 255 && ma == 0) return bf16div_pkg::QNan;
      return {sgn, 15'd0};
    end
    if (eb == 0 && mb == 0) begin
      if (ea == 0 && ma == 0) return bf16div_pkg::QNan;
      return {sgn, 15'd0} | bf16div_pkg::InfBits;
    end
    if (ea == 255) begin
      if (ma != 0) return a;
      return {sgn, 15'd0} | bf16div_pkg::InfBits;
    end
    if (ea == 0 && ma == 0) return {sgn, 15'd0};
    if (ea != 0) ma[7] = 1'b1;
    if (eb != 0) mb[7] = 1'b1;
    rem = ma << 15;
    q = 0;
    for (i = 0; i < 16; i++) begin
      q = q << 1;
      if (rem >= (mb << (15 - i))) begin
        rem = rem - (mb << (15 - i));
        q[0] = 1'b1;
      end
    end
    q = q & 32'hFFFF;
    e = ea - eb + 127;
    if (ea == 0) e--;
    if (eb == 0) e++;
    while (q[15] == 1'b0 && e > 1) begin
      q = (q << 1) & 32'hFFFF;
      e--;
    end
    if (e >= 255) return {sgn, 15'd0} | bf16div_pkg::InfBits;
    if (e <= 0) return {sgn, 15'd0};
    return {sgn, e[7:0], q[14:8]};
  endfunction

  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] random_word();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 9))
      0: w[14:7] = 8'hFF;
      1: w[14:7] = 8'h00;
      2: w[6:0] = 7'd0;
      3: w[14:7] = 8'(124 + $urandom_range(0, 6));
      default: ;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(logic [15:0] got, logic [15:0] want);
    $display("mismatch at %0t: quotient_word %h, expected %h", $time, got, want);
    mismatch_count++;
  endtask

  // Driver: offers the head of the pending queue, with random gaps between transfers.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.dividend_word <= '0;
      in_ch.divisor_word <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_quotients.push_back(bf16_quotient(in_ch.dividend_word, in_ch.divisor_word));
        transfers_in++;
        send_gap = random_gap();
      end
      if ((!in_ch.valid || in_ch.ready)) begin
        if (send_gap == 0 && !drain_pause && pending_pairs.size() > 0) begin
          in_ch.valid <= 1'b1;
          {in_ch.dividend_word, in_ch.divisor_word} <= pending_pairs.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // Monitor: checks each result transfer and throttles ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        transfers_out++;
        if (expected_quotients.size() == 0) begin
          $display("unexpected result at %0t: quotient_word %h", $time, out_ch.quotient_word);
          mismatch_count++;
        end else if (out_ch.quotient_word !== expected_quotients[0]) begin
          report_mismatch(out_ch.quotient_word, expected_quotients.pop_front());
        end else begin
          void'(expected_quotients.pop_front());
        end
        recv_gap = random_gap();
      end
      if (transfers_in == 300 && hold_off == 0) hold_off = 400;
      if (hold_off > 1) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 9) != 0) || transfers_in > 1800;
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] directed[$];
    int i, j;
    directed = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0, 16'hFFFF, 16'h0001,
                 16'h807F, 16'h3F80, 16'h4000, 16'h7F7F, 16'h0080};
    for (i = 0; i < 5; i++)
      for (j = 0; j < 5; j++) pending_pairs.push_back({directed[i], directed[j]});
    for (i = 0; i < 12; i++) pending_pairs.push_back({directed[i], directed[11 - i]});
    for (i = 0; i < 200; i++) pending_pairs.push_back({random_word(), random_word()});
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_pairs.size() == 0 && transfers_in > 230 && !in_ch.valid);
    drain_pause = 1'b1;
    wait (expected_quotients.size() == 0);
    repeat (30) @(posedge clk);
    drain_pause = 1'b0;
    for (i = 0; i < 1800; i++) pending_pairs.push_back({random_word(), random_word()});
    wait (pending_pairs.size() == 0 && !in_ch.valid);
    wait (expected_quotients.size() == 0);
    repeat (60) @(posedge clk);
    $display("Covered %0d operand transfers and %0d quotient transfers,", transfers_in,
             transfers_out);
    $display("including special encodings, subnormals, a long output stall and a drain pause.");
    if (mismatch_count == 0 && expected_quotients.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
